[src/cmli_pkg.sv]
`default_nettype none

package cmli_pkg;

  localparam int unsigned MAX_POINTS_DEF = 16;
  localparam int unsigned POS_BITS       = 16;
  localparam int unsigned CHAN_W         = 8;
  localparam int unsigned NUM_CHAN       = 4;
  localparam int unsigned FRAC_BITS      = 16;
  localparam int unsigned IDX_W          = 4;
  localparam int unsigned CFG_W          = 5;

  // table entry: {a, b, g, r, pos}
  localparam int unsigned ENTRY_W = POS_BITS + NUM_CHAN * CHAN_W;

  // input word: point_index, point_pos, r, g, b, a, query_pos, zero pad
  localparam int unsigned S_FIELDS_W = IDX_W + 2 * POS_BITS + NUM_CHAN * CHAN_W;
  localparam int unsigned S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned M_DATA_W   = NUM_CHAN * CHAN_W;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LO,
    S_WALK,
    S_SETUP,
    S_DIV,
    S_BLEND
  } state_e;

endpackage

`default_nettype wire

[src/cmli_ram.sv]
`default_nettype none

module cmli_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[src/color_map_linear_interpolator.sv]
// Write word: taken while idle, no result.
// Query word: reads point 0 (S_LO), walks 1 .. points-1 table reads (S_WALK), sets up
// (S_SETUP), divides bit-serially (S_DIV) only if the position is strictly inside a segment,
// and loads the result (S_BLEND) once the output is free. One word is in work at a time.
// Under two points: no walk, no divide. Next word taken in the cycle after the result loads.
// Reset clears the FSM, output valid and points_in_use; table contents stay undefined.
`default_nettype none

module color_map_linear_interpolator #(
  parameter int unsigned MAX_POINTS = cmli_pkg::MAX_POINTS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [cmli_pkg::CFG_W-1:0]    cfg_wdata_i,    // points_in_use
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [3:0] point_index, [19:4] point_pos, [27:20] point_red, [35:28] point_green,
  // [43:36] point_blue, [51:44] point_alpha, [67:52] query_pos, rest zero
  input  wire logic [cmli_pkg::S_DATA_W-1:0] s_axis_tdata,
  input  wire logic                          s_axis_tuser,   // cmd
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [7:0] out_red, [15:8] out_green, [23:16] out_blue, [31:24] out_alpha
  output logic      [cmli_pkg::M_DATA_W-1:0] m_axis_tdata,
  output logic                               m_axis_tuser    // color_valid
);

  import cmli_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_POINTS);
  localparam int unsigned CW    = $clog2(MAX_POINTS + 1);
  localparam int unsigned CMP_W = (CW > CFG_W) ? CW : CFG_W;
  localparam int unsigned DCW   = $clog2(FRAC_BITS);
  localparam int unsigned D_W   = FRAC_BITS + 1;
  localparam int unsigned PRD_W = CHAN_W + 1 + D_W + 1;

  localparam int unsigned IDX_LSB  = 0;
  localparam int unsigned PPOS_LSB = IDX_LSB + IDX_W;
  localparam int unsigned CHAN_LSB = PPOS_LSB + POS_BITS;
  localparam int unsigned QPOS_LSB = CHAN_LSB + NUM_CHAN * CHAN_W;

  state_e state_q, state_d;

  logic [CFG_W-1:0]    cfg_q;
  logic [CW-1:0]       n_eff, n_last;
  logic                too_few;

  logic [POS_BITS-1:0] q_q;
  logic [AW-1:0]       k_q;
  logic                zero_q;
  logic [ENTRY_W-1:0]  lo_q, hi_q;
  logic [POS_BITS-1:0] rem_q;
  logic [POS_BITS:0]   rem_d;
  logic [POS_BITS-1:0] den_q;
  logic [D_W-1:0]      d_q;
  logic [DCW-1:0]      div_cnt_q;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;

  logic                in_acc, is_query, slot_ok;
  logic                walk_stop, seg_lo, seg_hi, div_ge, div_done, out_load;
  logic [POS_BITS:0]   rem_sh;

  logic [POS_BITS-1:0] xlo, xhi, xk;
  logic [M_DATA_W-1:0] blend;
  logic signed [CHAN_W:0]  chan_diff [NUM_CHAN];
  logic signed [PRD_W-1:0] chan_prod [NUM_CHAN];

  // effective point count, saturated at table depth
  always_comb begin
    if (CMP_W'(cfg_q) > CMP_W'(MAX_POINTS)) begin
      n_eff = CW'(MAX_POINTS);
    end else begin
      n_eff = CW'(cfg_q);
    end
    n_last  = n_eff - CW'(1);
    too_few = n_eff < CW'(2);
  end

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign is_query = (s_axis_tuser == CMD_QUERY);
  assign slot_ok  = 32'(s_axis_tdata[PPOS_LSB-1:IDX_LSB]) < 32'(MAX_POINTS);

  assign ram_waddr = AW'(s_axis_tdata[PPOS_LSB-1:IDX_LSB]);
  assign ram_wdata = s_axis_tdata[QPOS_LSB-1:PPOS_LSB];

  cmli_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_POINTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign xk  = ram_rdata[POS_BITS-1:0];
  assign xlo = lo_q[POS_BITS-1:0];
  assign xhi = hi_q[POS_BITS-1:0];

  // walk ends at the first breakpoint past the query, or at the last point
  assign walk_stop = (xk > q_q) || (CW'(k_q) == n_last);
  assign seg_lo    = (xhi <= xlo) || (q_q <= xlo);
  assign seg_hi    = (q_q >= xhi);

  // restoring divide step
  assign rem_sh   = {rem_q, 1'b0};
  assign div_ge   = rem_sh >= {1'b0, den_q};
  assign rem_d    = div_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
  assign div_done = (div_cnt_q == DCW'(FRAC_BITS - 1));

  assign out_load = (state_q == S_BLEND) && (!m_axis_tvalid || m_axis_tready);

  // lo + round((hi - lo) * d), the low byte of the shifted sum carries the step
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      chan_diff[c] = $signed({1'b0, hi_q[POS_BITS + c*CHAN_W +: CHAN_W]})
                   - $signed({1'b0, lo_q[POS_BITS + c*CHAN_W +: CHAN_W]});
      chan_prod[c] = PRD_W'(chan_diff[c] * $signed({1'b0, d_q}))
                   + PRD_W'(1 << (FRAC_BITS - 1));
      blend[c*CHAN_W +: CHAN_W] = lo_q[POS_BITS + c*CHAN_W +: CHAN_W]
                                + chan_prod[c][FRAC_BITS +: CHAN_W];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && is_query) begin
          state_d = too_few ? S_BLEND : S_LO;
        end
      end
      S_LO:    state_d = S_WALK;
      S_WALK: begin
        if (walk_stop) begin
          state_d = S_SETUP;
        end
      end
      S_SETUP: state_d = (seg_lo || seg_hi) ? S_BLEND : S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_d = S_BLEND;
        end
      end
      S_BLEND: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_raddr     = '0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        ram_we        = in_acc && !is_query && slot_ok;
      end
      S_LO:   ram_raddr = k_q;
      S_WALK: ram_raddr = k_q + AW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cfg_q         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc && is_query) begin
          q_q    <= s_axis_tdata[QPOS_LSB +: POS_BITS];
          k_q    <= AW'(1);
          zero_q <= too_few;
        end
      end
      S_LO: lo_q <= ram_rdata;
      S_WALK: begin
        if (walk_stop) begin
          hi_q <= ram_rdata;
        end else begin
          lo_q <= ram_rdata;
          k_q  <= k_q + AW'(1);
        end
      end
      S_SETUP: begin
        rem_q     <= q_q - xlo;
        den_q     <= xhi - xlo;
        div_cnt_q <= '0;
        if (!seg_lo && seg_hi) begin
          d_q <= D_W'(1 << FRAC_BITS);
        end else begin
          d_q <= '0;
        end
      end
      S_DIV: begin
        rem_q     <= rem_d[POS_BITS-1:0];
        d_q       <= {d_q[D_W-2:0], div_ge};
        div_cnt_q <= div_cnt_q + DCW'(1);
      end
      default: ;
    endcase

    if (out_load) begin
      m_axis_tdata <= zero_q ? '0 : blend;
      m_axis_tuser <= !zero_q;
    end
  end

endmodule

`default_nettype wire
